/* hdl/sdp_pkg.sv */
// Shared constants, types and step table for the SPS dimension parser.
// No dependencies.
package sdp_pkg;

  // syntax step codes
  localparam logic [5:0] ST_PROFILE  = 6'd0;
  localparam logic [5:0] ST_CONSTR   = 6'd1;
  localparam logic [5:0] ST_LEVEL    = 6'd2;
  localparam logic [5:0] ST_SPSID    = 6'd3;
  localparam logic [5:0] ST_CHROMA   = 6'd4;
  localparam logic [5:0] ST_SEPPLANE = 6'd5;
  localparam logic [5:0] ST_BDL      = 6'd6;
  localparam logic [5:0] ST_BDC      = 6'd7;
  localparam logic [5:0] ST_BYPASS   = 6'd8;
  localparam logic [5:0] ST_MATRIX   = 6'd9;
  localparam logic [5:0] ST_LISTFLAG = 6'd10;
  localparam logic [5:0] ST_DELTA    = 6'd11;
  localparam logic [5:0] ST_LOG2FN   = 6'd12;
  localparam logic [5:0] ST_POCTYPE  = 6'd13;
  localparam logic [5:0] ST_LOG2POC  = 6'd14;
  localparam logic [5:0] ST_DZERO    = 6'd15;
  localparam logic [5:0] ST_OFFNR    = 6'd16;
  localparam logic [5:0] ST_OFFTB    = 6'd17;
  localparam logic [5:0] ST_CYCLE    = 6'd18;
  localparam logic [5:0] ST_CYCOFF   = 6'd19;
  localparam logic [5:0] ST_MAXREF   = 6'd20;
  localparam logic [5:0] ST_GAPS     = 6'd21;
  localparam logic [5:0] ST_WIDTH    = 6'd22;
  localparam logic [5:0] ST_HEIGHT   = 6'd23;
  localparam logic [5:0] ST_FMO      = 6'd24;
  localparam logic [5:0] ST_MBAFF    = 6'd25;
  localparam logic [5:0] ST_D8       = 6'd26;
  localparam logic [5:0] ST_CROPF    = 6'd27;
  localparam logic [5:0] ST_CROP0    = 6'd28;
  localparam logic [5:0] ST_CROP1    = 6'd29;
  localparam logic [5:0] ST_CROP2    = 6'd30;
  localparam logic [5:0] ST_CROP3    = 6'd31;
  localparam logic [5:0] ST_VUI      = 6'd32;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;

  // outcome of a byte
  localparam logic [1:0] RES_NONE = 2'd0;
  localparam logic [1:0] RES_OK   = 2'd1;
  localparam logic [1:0] RES_OVF  = 2'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } byte_t;

  // queue to engine handshake
  typedef struct packed {
    logic  valid;
    byte_t data;
  } q_out_t;

  // fixed field length per step; zero means Exp-Golomb
  function automatic logic [3:0] fixed_len(input logic [5:0] step);
    logic [3:0] len;
    case (step)
      ST_PROFILE, ST_CONSTR, ST_LEVEL: len = 4'd8;
      ST_SEPPLANE, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DZERO,
      ST_GAPS, ST_FMO, ST_MBAFF, ST_D8, ST_CROPF, ST_VUI: len = 4'd1;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

/* hdl/sdp_if.sv */
// Valid/ready channel interfaces for the SPS dimension parser.
// Depends on nothing.
interface sdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;
  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface sdp_out_if #(parameter int DIM_BITS = 16);
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] frame_width;
  logic [DIM_BITS-1:0] frame_height;
  logic [1:0]          parse_status;
  modport source (output valid, output frame_width, output frame_height,
                  output parse_status, input ready);
  modport sink (input valid, input frame_width, input frame_height,
                input parse_status, output ready);
endinterface

/* hdl/sdp_front.sv */
// Front end: accepts bytes into a two-entry queue ahead of the syntax engine.
// Depends on sdp_pkg and sdp_if.
module sdp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  sdp_in_if.sink          in_i,
  input  logic            pop_i,
  output sdp_pkg::q_out_t q_o
);
  sdp_pkg::byte_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != 2'd0);
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.data   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].payload_byte <= in_i.payload_byte;
      mem_q[wp_q].last_byte    <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* hdl/sdp_back.sv */
// Back end: bit-serial SPS syntax engine with Exp-Golomb decode and result register.
// Depends on sdp_pkg and sdp_if.
module sdp_back #(
  parameter int GOLOMB_BITS = 32,
  parameter int DIM_BITS    = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sdp_pkg::q_out_t q_i,
  output logic            pop_o,
  sdp_out_if.source       out_o
);
  localparam int G   = GOLOMB_BITS;
  localparam int LZW = $clog2(GOLOMB_BITS + 1);
  localparam int SW  = GOLOMB_BITS + 8;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_BITS = 3'b010,
    BK_END  = 3'b100
  } bk_state_e;

  bk_state_e      st_q, st_d;
  logic [7:0]     sh_q;
  logic [2:0]     cnt_q;
  logic           last_q;
  logic [5:0]     step_q, step_d;
  logic           gph_q, gph_d;
  logic [LZW-1:0] lz_q, lz_d, brem_q, brem_d;
  logic [G-1:0]   acc_q, acc_d;
  logic [7:0]     prof_q, prof_d;
  logic [3:0]     lidx_q, lidx_d;
  logic [6:0]     lpos_q, lpos_d;
  logic [7:0]     prev_q, prev_d;
  logic [G-1:0]   poc_q, poc_d;
  logic [G-1:0]   wmb_q, wmb_d, hmu_q, hmu_d;
  logic           prog_q, prog_d, c444_q, c444_d, fin_q, fin_d;
  logic [G-1:0]   crop_q [4];
  logic [G-1:0]   crop_d [4];
  logic [1:0]     res_q, res_d;

  logic                out_v_q;
  logic [DIM_BITS-1:0] ow_q, oh_q;
  logic [1:0]          os_q;

  // per-bit decode
  logic           b, done, bgn;
  logic [5:0]     bstep;
  logic [G-1:0]   v, acc_sh;
  logic [LZW-1:0] brem_dec, lz_inc;
  logic [7:0]     delta, up;
  logic [G-1:0]   poc_dec;
  logic [6:0]     lsize;
  logic [3:0]     lidx_n;

  // result arithmetic
  logic signed [SW-1:0] w_s, h_s, max_s;
  logic [DIM_BITS-1:0]  w_sat, h_sat;

  assign b        = sh_q[7];
  assign acc_sh   = {acc_q[G-2:0], b};
  assign brem_dec = (brem_q != '0) ? brem_q - LZW'(1) : '0;
  assign lz_inc   = lz_q + LZW'(1);
  assign poc_dec  = (poc_q != '0) ? poc_q - G'(1) : '0;
  assign lsize    = (lidx_q < 4'd6) ? 7'd16 : 7'd64;

  always_comb begin
    done     = 1'b0;
    v        = '0;
    bgn      = 1'b0;
    bstep    = step_q;
    delta    = '0;
    up       = '0;
    lidx_n   = lidx_q + 4'd1;
    st_d     = st_q;
    step_d   = step_q;
    gph_d    = gph_q;
    lz_d     = lz_q;
    brem_d   = brem_q;
    acc_d    = acc_q;
    prof_d   = prof_q;
    lidx_d   = lidx_q;
    lpos_d   = lpos_q;
    prev_d   = prev_q;
    poc_d    = poc_q;
    wmb_d    = wmb_q;
    hmu_d    = hmu_q;
    prog_d   = prog_q;
    c444_d   = c444_q;
    fin_d    = fin_q;
    crop_d   = crop_q;
    res_d    = res_q;

    if (st_q == BK_BITS && !fin_q) begin
      if (sdp_pkg::fixed_len(step_q) != 4'd0) begin
        acc_d  = acc_sh;
        brem_d = brem_dec;
        if (brem_dec == '0) begin
          done = 1'b1;
          v    = acc_sh;
        end
      end else if (!gph_q) begin
        if (!b) begin
          lz_d = lz_inc;
          if (lz_inc == LZW'(GOLOMB_BITS)) begin
            fin_d = 1'b1;
            res_d = sdp_pkg::RES_OVF;
          end
        end else if (lz_q == '0) begin
          done = 1'b1;
        end else begin
          gph_d  = 1'b1;
          brem_d = lz_q;
          acc_d  = '0;
        end
      end else begin
        acc_d  = acc_sh;
        brem_d = brem_dec;
        if (brem_dec == '0) begin
          done = 1'b1;
          v    = acc_sh + ~({G{1'b1}} << lz_q);
        end
      end

      if (done) begin
        bgn = 1'b1;
        case (step_q)
          sdp_pkg::ST_PROFILE: begin
            prof_d = v[7:0];
            bstep  = sdp_pkg::ST_CONSTR;
          end
          sdp_pkg::ST_CONSTR: bstep = sdp_pkg::ST_LEVEL;
          sdp_pkg::ST_LEVEL:  bstep = sdp_pkg::ST_SPSID;
          sdp_pkg::ST_SPSID: begin
            if (prof_q == 8'd100 || prof_q == 8'd110 || prof_q == 8'd122 ||
                prof_q == 8'd244 || prof_q == 8'd44 || prof_q == 8'd83 ||
                prof_q == 8'd86 || prof_q == 8'd118)
              bstep = sdp_pkg::ST_CHROMA;
            else
              bstep = sdp_pkg::ST_LOG2FN;
          end
          sdp_pkg::ST_CHROMA: begin
            c444_d = (v == G'(3));
            bstep  = (v == G'(3)) ? sdp_pkg::ST_SEPPLANE : sdp_pkg::ST_BDL;
          end
          sdp_pkg::ST_SEPPLANE: bstep = sdp_pkg::ST_BDL;
          sdp_pkg::ST_BDL:      bstep = sdp_pkg::ST_BDC;
          sdp_pkg::ST_BDC:      bstep = sdp_pkg::ST_BYPASS;
          sdp_pkg::ST_BYPASS:   bstep = sdp_pkg::ST_MATRIX;
          sdp_pkg::ST_MATRIX: begin
            if (v != '0) begin
              lidx_d = 4'd0;
              bstep  = sdp_pkg::ST_LISTFLAG;
            end else begin
              bstep = sdp_pkg::ST_LOG2FN;
            end
          end
          sdp_pkg::ST_LISTFLAG: begin
            if (v != '0) begin
              lpos_d = 7'd0;
              prev_d = 8'd8;
              bstep  = sdp_pkg::ST_DELTA;
            end else begin
              lidx_d = lidx_n;
              bstep  = (lidx_n < (c444_q ? 4'd12 : 4'd8)) ?
                       sdp_pkg::ST_LISTFLAG : sdp_pkg::ST_LOG2FN;
            end
          end
          sdp_pkg::ST_DELTA: begin
            // signed Exp-Golomb mapping, modulo 256
            delta  = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
            up     = prev_q + delta;
            if (up != 8'd0) prev_d = up;
            lpos_d = lpos_q + 7'd1;
            if ((lpos_q + 7'd1) >= lsize || up == 8'd0) begin
              lidx_d = lidx_n;
              bstep  = (lidx_n < (c444_q ? 4'd12 : 4'd8)) ?
                       sdp_pkg::ST_LISTFLAG : sdp_pkg::ST_LOG2FN;
            end else begin
              bstep = sdp_pkg::ST_DELTA;
            end
          end
          sdp_pkg::ST_LOG2FN: bstep = sdp_pkg::ST_POCTYPE;
          sdp_pkg::ST_POCTYPE: begin
            if (v == '0)        bstep = sdp_pkg::ST_LOG2POC;
            else if (v == G'(1)) bstep = sdp_pkg::ST_DZERO;
            else                bstep = sdp_pkg::ST_MAXREF;
          end
          sdp_pkg::ST_LOG2POC: bstep = sdp_pkg::ST_MAXREF;
          sdp_pkg::ST_DZERO:   bstep = sdp_pkg::ST_OFFNR;
          sdp_pkg::ST_OFFNR:   bstep = sdp_pkg::ST_OFFTB;
          sdp_pkg::ST_OFFTB:   bstep = sdp_pkg::ST_CYCLE;
          sdp_pkg::ST_CYCLE: begin
            poc_d = v;
            bstep = (v != '0) ? sdp_pkg::ST_CYCOFF : sdp_pkg::ST_MAXREF;
          end
          sdp_pkg::ST_CYCOFF: begin
            poc_d = poc_dec;
            bstep = (poc_dec != '0) ? sdp_pkg::ST_CYCOFF : sdp_pkg::ST_MAXREF;
          end
          sdp_pkg::ST_MAXREF: bstep = sdp_pkg::ST_GAPS;
          sdp_pkg::ST_GAPS:   bstep = sdp_pkg::ST_WIDTH;
          sdp_pkg::ST_WIDTH: begin
            wmb_d = v;
            bstep = sdp_pkg::ST_HEIGHT;
          end
          sdp_pkg::ST_HEIGHT: begin
            hmu_d = v;
            bstep = sdp_pkg::ST_FMO;
          end
          sdp_pkg::ST_FMO: begin
            prog_d = v[0];
            bstep  = v[0] ? sdp_pkg::ST_D8 : sdp_pkg::ST_MBAFF;
          end
          sdp_pkg::ST_MBAFF: bstep = sdp_pkg::ST_D8;
          sdp_pkg::ST_D8:    bstep = sdp_pkg::ST_CROPF;
          sdp_pkg::ST_CROPF:
            bstep = (v != '0) ? sdp_pkg::ST_CROP0 : sdp_pkg::ST_VUI;
          sdp_pkg::ST_CROP0, sdp_pkg::ST_CROP1, sdp_pkg::ST_CROP2,
          sdp_pkg::ST_CROP3: begin
            crop_d[step_q[1:0]] = v;
            bstep = step_q + 6'd1;
          end
          sdp_pkg::ST_VUI: begin
            bgn   = 1'b0;
            fin_d = 1'b1;
            res_d = sdp_pkg::RES_OK;
          end
          default: bstep = sdp_pkg::ST_PROFILE;
        endcase
      end

      if (bgn) begin
        step_d = bstep;
        gph_d  = 1'b0;
        lz_d   = '0;
        acc_d  = '0;
        brem_d = LZW'(sdp_pkg::fixed_len(bstep));
      end
    end

    // the byte marked last rearms the parser
    if (st_q == BK_END && last_q) begin
      step_d = sdp_pkg::ST_PROFILE;
      gph_d  = 1'b0;
      lz_d   = '0;
      acc_d  = '0;
      brem_d = LZW'(sdp_pkg::fixed_len(sdp_pkg::ST_PROFILE));
      prof_d = '0;
      lidx_d = '0;
      lpos_d = '0;
      prev_d = 8'd8;
      poc_d  = '0;
      wmb_d  = '0;
      hmu_d  = '0;
      prog_d = 1'b0;
      c444_d = 1'b0;
      fin_d  = 1'b0;
      crop_d = '{default: '0};
    end

    case (st_q)
      BK_IDLE: if (q_i.valid && !out_v_q) st_d = BK_BITS;
      BK_BITS: if (cnt_q == 3'd7) st_d = BK_END;
      BK_END:  st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  assign pop_o = (st_q == BK_IDLE) && q_i.valid && !out_v_q;

  // cropped dimensions, crop unit two
  assign w_s = (SW'(wmb_q) + SW'(1)) * SW'(16)
             - ((SW'(crop_q[0]) + SW'(crop_q[1])) <<< 1);
  assign h_s = ((SW'(hmu_q) + SW'(1)) <<< (prog_q ? 4 : 5))
             - ((SW'(crop_q[2]) + SW'(crop_q[3])) <<< 1);
  assign max_s = SW'({DIM_BITS{1'b1}});
  assign w_sat = w_s[SW-1] ? '0 : ((w_s > max_s) ? {DIM_BITS{1'b1}} : w_s[DIM_BITS-1:0]);
  assign h_sat = h_s[SW-1] ? '0 : ((h_s > max_s) ? {DIM_BITS{1'b1}} : h_s[DIM_BITS-1:0]);

  assign out_o.valid        = out_v_q;
  assign out_o.frame_width  = ow_q;
  assign out_o.frame_height = oh_q;
  assign out_o.parse_status = os_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) sh_q <= q_i.data.payload_byte;
    else if (st_q == BK_BITS) sh_q <= {sh_q[6:0], 1'b0};
    if (pop_o) last_q <= q_i.data.last_byte;
    if (st_q == BK_END) begin
      if (res_q == sdp_pkg::RES_OK) begin
        ow_q <= w_sat;
        oh_q <= h_sat;
        os_q <= sdp_pkg::STAT_OK;
      end else if (res_q == sdp_pkg::RES_OVF) begin
        ow_q <= '0;
        oh_q <= '0;
        os_q <= sdp_pkg::STAT_OVF;
      end else begin
        ow_q <= '0;
        oh_q <= '0;
        os_q <= sdp_pkg::STAT_SHORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_IDLE;
      cnt_q   <= '0;
      step_q  <= sdp_pkg::ST_PROFILE;
      gph_q   <= 1'b0;
      lz_q    <= '0;
      brem_q  <= LZW'(sdp_pkg::fixed_len(sdp_pkg::ST_PROFILE));
      acc_q   <= '0;
      prof_q  <= '0;
      lidx_q  <= '0;
      lpos_q  <= '0;
      prev_q  <= 8'd8;
      poc_q   <= '0;
      wmb_q   <= '0;
      hmu_q   <= '0;
      prog_q  <= 1'b0;
      c444_q  <= 1'b0;
      fin_q   <= 1'b0;
      crop_q  <= '{default: '0};
      res_q   <= sdp_pkg::RES_NONE;
      out_v_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      gph_q  <= gph_d;
      lz_q   <= lz_d;
      brem_q <= brem_d;
      acc_q  <= acc_d;
      prof_q <= prof_d;
      lidx_q <= lidx_d;
      lpos_q <= lpos_d;
      prev_q <= prev_d;
      poc_q  <= poc_d;
      wmb_q  <= wmb_d;
      hmu_q  <= hmu_d;
      prog_q <= prog_d;
      c444_q <= c444_d;
      fin_q  <= fin_d;
      crop_q <= crop_d;
      if (st_q == BK_BITS) cnt_q <= cnt_q + 3'd1;
      else cnt_q <= '0;
      if (st_q == BK_END) res_q <= sdp_pkg::RES_NONE;
      else res_q <= res_d;
      if (out_v_q && out_o.ready) out_v_q <= 1'b0;
      else if (st_q == BK_END &&
               (res_q != sdp_pkg::RES_NONE || (last_q && !fin_q))) out_v_q <= 1'b1;
    end
  end
endmodule

/* hdl/h264_sps_dimension_parser.sv */
// Top level of the H.264 SPS dimension parser: byte queue plus syntax engine.
// Depends on sdp_pkg, sdp_if, sdp_front and sdp_back.
//
// Feed the SPS payload from its first (profile) byte on, one byte per item, with
// last_byte on the final byte. Bytes land in a two-entry queue; the syntax engine takes a
// byte out, consumes its bits one per cycle and then closes the byte. A result (cropped
// width and height, or an error status) sits in an output register; the engine does not
// start the next byte until that result is taken, while the queue keeps accepting until
// both entries are full.
module h264_sps_dimension_parser #(
  parameter int GOLOMB_BITS = 32,
  parameter int DIM_BITS    = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  sdp_in_if.sink    in_i,
  sdp_out_if.source out_o
);
  sdp_pkg::q_out_t q;
  logic            pop;

  sdp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .q_o    (q)
  );

  sdp_back #(
    .GOLOMB_BITS (GOLOMB_BITS),
    .DIM_BITS    (DIM_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q),
    .pop_o  (pop),
    .out_o  (out_o)
  );
endmodule

/* hdl/sdp_checker.sv */
// Port-level checks for the SPS dimension parser, bound to the top level.
// Depends on sdp_pkg.
module sdp_checker #(
  parameter int DIM_BITS = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DIM_BITS-1:0] frame_width,
  input logic [DIM_BITS-1:0] frame_height,
  input logic [1:0]          parse_status
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(frame_width) &&
      $stable(frame_height) && $stable(parse_status))
    else $error("result changed while stalled");

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> parse_status == sdp_pkg::STAT_OK ||
      parse_status == sdp_pkg::STAT_SHORT || parse_status == sdp_pkg::STAT_OVF)
    else $error("bad status code");

  // error results carry zero dimensions
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && parse_status != sdp_pkg::STAT_OK |->
      frame_width == '0 && frame_height == '0)
    else $error("error result with dimensions");
endmodule

bind h264_sps_dimension_parser sdp_checker #(.DIM_BITS(DIM_BITS)) u_sdp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .frame_width  (out_o.frame_width),
  .frame_height (out_o.frame_height),
  .parse_status (out_o.parse_status)
);
